// ----- sv/identical_row_grouping_unit_assert.svh -----
// Assertion macros for the row grouping unit.
// Each macro expects clk and rst to be visible where it is used.
`ifndef IDENTICAL_ROW_GROUPING_UNIT_ASSERT_SVH
`define IDENTICAL_ROW_GROUPING_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IRG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IRG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/irg_pkg.sv -----
// Shared types and constants for the row grouping unit.
// Used by irg_table and identical_row_grouping_unit; depends on nothing.
package irg_pkg;

  localparam int KEY_W   = 32;
  localparam int FIRST_W = 12;
  localparam int SIZE_W  = 13;
  localparam int CFG_W   = 4;
  localparam int KIND_W  = 2;
  localparam int OUT_W   = 32;

  localparam int DEF_MAX_ROWS   = 4096;
  localparam int DEF_MAX_GROUPS = 64;
  localparam int DEF_MAX_COLS   = 8;
  localparam int DEF_CODE_BITS  = 4;

  localparam logic [CFG_W-1:0]  COLS_RESET = 4'd8;
  localparam logic [SIZE_W-1:0] SIZE_SAT   = '1;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_DUMP   = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LABEL = 2'd0,
    KIND_GROUP = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_TEST,
    ST_OPEN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [FIRST_W-1:0] first_row;
    logic [SIZE_W-1:0]  size;
  } entry_t;

  typedef struct packed {
    logic               match;
    logic [KEY_W-1:0]   key;
    logic [FIRST_W-1:0] first_row;
    logic [SIZE_W-1:0]  size;
  } hit_t;

  typedef struct packed {
    kind_t              kind;
    logic [FIRST_W-1:0] first_row;
    logic [SIZE_W-1:0]  size;
    logic               is_new;
    logic               overflow;
    logic               last;
  } result_t;

endpackage

// ----- sv/irg_table.sv -----
// Group table: one memory of key, first row and size per group, with a
// registered read port and the masked key comparator. Depends on irg_pkg.
module irg_table #(
  parameter int GROUPS = irg_pkg::DEF_MAX_GROUPS,
  parameter int AW     = 6
) (
  input  logic                      clk,
  input  logic                      wen,
  input  logic [AW-1:0]             waddr,
  input  irg_pkg::entry_t           wdata,
  input  logic [AW-1:0]             raddr,
  input  logic [irg_pkg::KEY_W-1:0] cmp_key,
  input  logic [irg_pkg::KEY_W-1:0] cmp_mask,
  output irg_pkg::hit_t             hit
);

  irg_pkg::entry_t mem [GROUPS];
  irg_pkg::entry_t q;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    q <= mem[raddr];
  end

  assign hit.match     = ((q.key ^ cmp_key) & cmp_mask) == '0;
  assign hit.key       = q.key;
  assign hit.first_row = q.first_row;
  assign hit.size      = q.size;

endmodule

// ----- sv/identical_row_grouping_unit.sv -----
// Row grouping unit: a sample row is read and tested against each stored group in turn;
// a match goes to output, no match goes to the open state to start a group, and a row past
// the row limit goes straight to output; each then waits for the output slot. A dump reads
// and emits each open group in turn, waiting on the output slot, or one empty marker if none.
// One beat is in flight at a time; the search loop over the table memory sets the rate.
// Synchronous reset empties the table at once and sets the compared column count to eight.
module identical_row_grouping_unit #(
  parameter int MAX_ROWS   = irg_pkg::DEF_MAX_ROWS,
  parameter int MAX_GROUPS = irg_pkg::DEF_MAX_GROUPS,
  parameter int MAX_COLS   = irg_pkg::DEF_MAX_COLS,
  parameter int CODE_BITS  = irg_pkg::DEF_CODE_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wen,
  input  logic [irg_pkg::CFG_W-1:0]  cfg_wdata,   // cols_in_use
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [irg_pkg::KEY_W-1:0]  s_tdata,     // row_key
  input  logic [0:0]                 s_tuser,     // op
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [irg_pkg::OUT_W-1:0]  m_tdata,     // first_row, group_size, is_new, overflow
  output logic [irg_pkg::KIND_W-1:0] m_tuser,     // kind
  output logic                       m_tlast
);

  localparam int AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int CW = $clog2(MAX_GROUPS + 1);
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int FW = irg_pkg::FIRST_W;
  localparam int SW = irg_pkg::SIZE_W;
  localparam int KW = irg_pkg::KEY_W;
  localparam int PAD_W = irg_pkg::OUT_W - FW - SW - 2;

  irg_pkg::state_t state, state_next;

  logic [irg_pkg::CFG_W-1:0] cols_in_use;
  logic [RW-1:0]             rows_seen;
  logic [CW-1:0]             groups_filled;
  logic                      op_q;
  logic [KW-1:0]             key_q;
  logic [RW-1:0]             row_q;
  logic [CW-1:0]             scan;
  irg_pkg::result_t          res;
  irg_pkg::result_t          out_q;

  logic                      accept;
  logic                      out_free;
  logic                      last_scan;
  logic                      rows_full;
  logic                      groups_full;
  logic [irg_pkg::CFG_W-1:0] cols_eff;
  logic [7:0]                mask_bits;
  logic [KW-1:0]             mask;
  logic [RW+FW-1:0]          row_ext;
  logic [FW-1:0]             row_first;
  logic [SW-1:0]             size_inc;

  logic                      tbl_wen;
  logic [AW-1:0]             tbl_waddr;
  irg_pkg::entry_t           tbl_wdata;
  irg_pkg::hit_t             hit;
  logic                      out_load;
  irg_pkg::result_t          out_next;

  assign accept      = s_tvalid && s_tready;
  assign out_free    = !m_tvalid || m_tready;
  assign last_scan   = (scan + CW'(1)) == groups_filled;
  assign rows_full   = rows_seen >= RW'(MAX_ROWS);
  assign groups_full = groups_filled >= CW'(MAX_GROUPS);
  assign row_ext     = {{FW{1'b0}}, row_q};
  assign row_first   = row_ext[FW-1:0];
  assign size_inc    = (hit.size == irg_pkg::SIZE_SAT) ? hit.size : hit.size + SW'(1);

  always_comb begin
    if (cols_in_use == '0) begin
      cols_eff = irg_pkg::CFG_W'(1);
    end else if (cols_in_use > irg_pkg::CFG_W'(MAX_COLS)) begin
      cols_eff = irg_pkg::CFG_W'(MAX_COLS);
    end else begin
      cols_eff = cols_in_use;
    end
    mask_bits = 8'(cols_eff) * 8'(CODE_BITS);
    for (int b = 0; b < KW; b++) begin
      mask[b] = 8'(b) < mask_bits;
    end
  end

  irg_table #(
    .GROUPS (MAX_GROUPS),
    .AW     (AW)
  ) u_table (
    .clk      (clk),
    .wen      (tbl_wen),
    .waddr    (tbl_waddr),
    .wdata    (tbl_wdata),
    .raddr    (scan[AW-1:0]),
    .cmp_key  (key_q),
    .cmp_mask (mask),
    .hit      (hit)
  );

  always_comb begin
    state_next = state;
    case (state)
      irg_pkg::ST_IDLE: begin
        if (accept) begin
          if (s_tuser[0] == irg_pkg::OP_DUMP) begin
            state_next = (groups_filled == '0) ? irg_pkg::ST_OUT : irg_pkg::ST_READ;
          end else if (rows_full) begin
            state_next = irg_pkg::ST_OUT;
          end else begin
            state_next = (groups_filled == '0) ? irg_pkg::ST_OPEN : irg_pkg::ST_READ;
          end
        end
      end
      irg_pkg::ST_READ: begin
        state_next = irg_pkg::ST_TEST;
      end
      irg_pkg::ST_TEST: begin
        if (op_q == irg_pkg::OP_DUMP) begin
          if (out_free) begin
            state_next = last_scan ? irg_pkg::ST_IDLE : irg_pkg::ST_READ;
          end
        end else if (hit.match) begin
          state_next = irg_pkg::ST_OUT;
        end else begin
          state_next = last_scan ? irg_pkg::ST_OPEN : irg_pkg::ST_READ;
        end
      end
      irg_pkg::ST_OPEN: begin
        state_next = irg_pkg::ST_OUT;
      end
      irg_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = irg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = irg_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    tbl_wen   = 1'b0;
    tbl_waddr = scan[AW-1:0];
    tbl_wdata = {hit.key, hit.first_row, size_inc};
    out_load  = 1'b0;
    out_next  = res;
    case (state)
      irg_pkg::ST_IDLE: begin
        s_tready = !rst;
      end
      irg_pkg::ST_TEST: begin
        if (op_q == irg_pkg::OP_DUMP) begin
          out_load           = out_free;
          out_next.kind      = irg_pkg::KIND_GROUP;
          out_next.first_row = hit.first_row;
          out_next.size      = hit.size;
          out_next.is_new    = 1'b0;
          out_next.overflow  = 1'b0;
          out_next.last      = last_scan;
        end else begin
          tbl_wen = hit.match;
        end
      end
      irg_pkg::ST_OPEN: begin
        tbl_wen   = !groups_full;
        tbl_waddr = groups_filled[AW-1:0];
        tbl_wdata = {key_q, row_first, SW'(1)};
      end
      irg_pkg::ST_OUT: begin
        out_load = out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= irg_pkg::ST_IDLE;
      cols_in_use   <= irg_pkg::COLS_RESET;
      rows_seen     <= '0;
      groups_filled <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        cols_in_use <= cfg_wdata;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        irg_pkg::ST_IDLE: begin
          if (accept) begin
            if (s_tuser[0] == irg_pkg::OP_DUMP) begin
              if (groups_filled == '0) begin
                rows_seen <= '0;
              end
            end else if (!rows_full) begin
              rows_seen <= rows_seen + RW'(1);
            end
          end
        end
        irg_pkg::ST_TEST: begin
          if (op_q == irg_pkg::OP_DUMP && out_free && last_scan) begin
            rows_seen     <= '0;
            groups_filled <= '0;
          end
        end
        irg_pkg::ST_OPEN: begin
          if (!groups_full) begin
            groups_filled <= groups_filled + CW'(1);
          end
        end
        default: begin
          rows_seen <= rows_seen;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_q <= out_next;
    end
    case (state)
      irg_pkg::ST_IDLE: begin
        op_q  <= s_tuser[0];
        key_q <= s_tdata;
        row_q <= rows_seen;
        scan  <= '0;
        if (s_tuser[0] == irg_pkg::OP_DUMP) begin
          res <= {irg_pkg::KIND_EMPTY, FW'(0), SW'(0), 1'b0, 1'b0, 1'b1};
        end else begin
          res <= {irg_pkg::KIND_LABEL, FW'(0), SW'(0), 1'b0, 1'b1, 1'b1};
        end
      end
      irg_pkg::ST_TEST: begin
        if (op_q == irg_pkg::OP_DUMP) begin
          if (out_free) begin
            scan <= scan + CW'(1);
          end
        end else if (hit.match) begin
          res.kind      <= irg_pkg::KIND_LABEL;
          res.first_row <= hit.first_row;
          res.size      <= size_inc;
          res.is_new    <= 1'b0;
          res.overflow  <= 1'b0;
          res.last      <= 1'b1;
        end else if (!last_scan) begin
          scan <= scan + CW'(1);
        end
      end
      irg_pkg::ST_OPEN: begin
        res.kind <= irg_pkg::KIND_LABEL;
        res.last <= 1'b1;
        if (groups_full) begin
          res.first_row <= '0;
          res.size      <= '0;
          res.is_new    <= 1'b0;
          res.overflow  <= 1'b1;
        end else begin
          res.first_row <= row_first;
          res.size      <= SW'(1);
          res.is_new    <= 1'b1;
          res.overflow  <= 1'b0;
        end
      end
      default: begin
        scan <= scan;
      end
    endcase
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_q.overflow, out_q.is_new, out_q.size, out_q.first_row};
  assign m_tuser = out_q.kind;
  assign m_tlast = out_q.last;

  `include "identical_row_grouping_unit_assert.svh"

  `IRG_ASSERT_SAME(a_groups_bounded, 1'b1, groups_filled <= CW'(MAX_GROUPS), "group count beyond table depth")
  `IRG_ASSERT_SAME(a_rows_bounded, 1'b1, rows_seen <= RW'(MAX_ROWS), "row counter beyond limit")
  `IRG_ASSERT_SAME(a_empty_is_last, m_tvalid && m_tuser == irg_pkg::KIND_EMPTY, m_tlast, "empty dump marker without last")
  `IRG_ASSERT_NEXT(a_row_counted, accept && s_tuser[0] == irg_pkg::OP_SAMPLE && !rows_full, rows_seen == $past(rows_seen) + RW'(1), "accepted row not counted")

endmodule
